@@ sv/crcu_pkg.sv @@
// Shared types, constants and CRC-32 helper functions for the CRC-32 byte updater.
// No dependencies; crcu_req_if, crcu_update and crc32_byte_updater refer to this package by scoped names.
package crcu_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_XOROUT  = 32'hFFFF_FFFF;
   localparam logic [31:0] INIT_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_RESET   = 32'hFFFF_FFFF;
   localparam logic [2:0]  MAX_BYTES   = 3'd4;

   typedef enum logic {
      ACTION_RESTART = 1'b0,
      ACTION_FEED    = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        reverse_bits;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] crc_final;
      logic [31:0] crc_reflected;
   } rsp_payload_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = b[i];
      end
      return r;
   endfunction

   function automatic logic [31:0] rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[31-i] = v[i];
      end
      return r;
   endfunction

   // one reflected table step: T[(reg ^ b) & 0xff] ^ (reg >> 8)
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c ^ (crc >> 8);
   endfunction

endpackage

@@ sv/crcu_req_if.sv @@
// Request channel interface: valid/ready handshake plus the input item fields.
// Depends on crcu_pkg for the action type.
interface crcu_req_if;
   logic                valid;
   logic                ready;
   crcu_pkg::action_type action;
   logic [31:0]         data_word;
   logic [2:0]          byte_count;
   logic                reverse_bits;

   modport source (output valid, action, data_word, byte_count, reverse_bits, input ready);
   modport sink   (input valid, action, data_word, byte_count, reverse_bits, output ready);
endinterface

@@ sv/crcu_rsp_if.sv @@
// Response channel interface: valid/ready handshake plus the result item fields.
// No package dependencies.
interface crcu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_final;
   logic [31:0] crc_reflected;

   modport source (output valid, crc_final, crc_reflected, input ready);
   modport sink   (input valid, crc_final, crc_reflected, output ready);
endinterface

@@ sv/crcu_csr_if.sv @@
// Configuration write channel interface: valid/ready and the init value write data.
// No package dependencies.
interface crcu_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

@@ sv/crcu_update.sv @@
// Combinational CRC-32 update for one item: restart or up to four unrolled byte steps,
// plus the final-XOR and bit-reversed result forms. Depends on crcu_pkg.
module crcu_update (
   input  logic [31:0]               crc_cur,
   input  logic [31:0]               init_value,
   input  crcu_pkg::req_payload_type item,
   output logic [31:0]               crc_next,
   output crcu_pkg::rsp_payload_type result
);

   logic [2:0]  count;
   logic [31:0] crc;
   logic [7:0]  b;

   always_comb begin
      count = (item.byte_count > crcu_pkg::MAX_BYTES) ? crcu_pkg::MAX_BYTES : item.byte_count;
      crc   = crc_cur;
      b     = 8'd0;
      case (item.action)
         crcu_pkg::ACTION_RESTART: begin
            crc = init_value;
         end
         crcu_pkg::ACTION_FEED: begin
            // most significant valid byte goes first
            for (int i = 3; i >= 0; i--) begin
               b = item.data_word[8*i +: 8];
               if (item.reverse_bits) begin
                  b = crcu_pkg::rev8(b);
               end
               if (3'(i) < count) begin
                  crc = crcu_pkg::crc_byte(crc, b);
               end
            end
         end
         default: begin
            crc = crc_cur;
         end
      endcase
      crc_next             = crc;
      result.crc_final     = crc ^ crcu_pkg::CRC_XOROUT;
      result.crc_reflected = crcu_pkg::rev32(crc);
   end

endmodule

@@ sv/crc32_byte_updater.sv @@
// CRC-32 byte updater top level: input register, CRC state and result register.
// A request passes the input reg, then the result reg, before its response is accepted.
// Throughput: one item per cycle while rsp_ch is not stalled; up to four byte steps in one pass.
// Reset: synchronous, active high; CRC register and init value return to all ones,
// both stages empty. Config writes are always accepted.
// Depends on crcu_pkg, crcu_req_if, crcu_rsp_if, crcu_csr_if and crcu_update.
module crc32_byte_updater (
   input logic         clock,
   input logic         reset,
   crcu_req_if.sink    req_ch,
   crcu_rsp_if.source  rsp_ch,
   crcu_csr_if.sink    csr_ch
);

   logic                      in_valid_ff, in_valid_in;
   crcu_pkg::req_payload_type in_ff, in_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   crcu_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [31:0]               crc_ff, crc_in;
   logic [31:0]               init_ff, init_in;
   logic [31:0]               crc_next;
   crcu_pkg::rsp_payload_type result;
   logic                      advance;
   logic                      req_take;

   crcu_update u_update (
      .crc_cur    (crc_ff),
      .init_value (init_ff),
      .item       (in_ff),
      .crc_next   (crc_next),
      .result     (result)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.crc_final     = rsp_ff.crc_final;
   assign rsp_ch.crc_reflected = rsp_ff.crc_reflected;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      crc_in       = crc_ff;
      init_in      = init_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = result;
         crc_in       = crc_next;
      end
      if (req_take) begin
         in_valid_in        = 1'b1;
         in_in.action       = req_ch.action;
         in_in.data_word    = req_ch.data_word;
         in_in.byte_count   = req_ch.byte_count;
         in_in.reverse_bits = req_ch.reverse_bits;
      end
      if (csr_ch.valid) begin
         init_in = csr_ch.wdata;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= crcu_pkg::CRC_RESET;
         init_ff      <= crcu_pkg::INIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         init_ff      <= init_in;
      end
   end

   // while valid, the result register mirrors the latest CRC state
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.crc_final == (crc_ff ^ crcu_pkg::CRC_XOROUT)))
      else $error("result register out of step with CRC state");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach result register");

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("stalled input item lost or changed");

   a_no_state_change_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(crc_ff))
      else $error("CRC state changed without an item");

endmodule
